// ===== design/depth_pixel_backprojection_core_macros.svh =====
// Assertion helpers for the back-projection core.
`ifndef DEPTH_PIXEL_BACKPROJECTION_CORE_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DPB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DPB_ASSERT_IMPL(lbl, ante, cons, msg)
`define DPB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/dpb_pkg.sv =====
`timescale 1ns / 1ps
package dpb_pkg;
  localparam int unsigned QBITS = 32;
  localparam int unsigned CoordBitsDefault = 12;
  localparam int unsigned CfgAddrBits = 3;

  localparam logic [CfgAddrBits-1:0] RegFocalX     = 3'd0;
  localparam logic [CfgAddrBits-1:0] RegFocalY     = 3'd1;
  localparam logic [CfgAddrBits-1:0] RegCenterX    = 3'd2;
  localparam logic [CfgAddrBits-1:0] RegCenterY    = 3'd3;
  localparam logic [CfgAddrBits-1:0] RegDepthScale = 3'd4;
  localparam logic [CfgAddrBits-1:0] RegInvalid    = 3'd5;

  localparam logic [31:0] DepthScaleReset = 32'd16777;
  localparam logic [39:0] InvalidTol      = 40'd65;
  localparam logic [39:0] MinDepth        = 40'd655;
  localparam logic [47:0] DepthRound      = 48'd128;
  localparam logic [7:0]  GrayLevel       = 8'd128;

  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        ovf_x;
    logic        ovf_y;
    logic [11:0] col;
    logic [11:0] row;
    logic [31:0] zs;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } side_t;

  typedef struct packed {
    logic [31:0] focal_x;
    logic [31:0] focal_y;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] depth_unit;
    logic [31:0] invalid_depth;
  } cfg_t;
endpackage

// ===== design/depth_pixel_backprojection_core.sv =====
`timescale 1ns / 1ps
// Channel      Dir  Fields (low bit first)
// s_axis       in   tdata: col_index, row_index, depth_raw, blue, green, red
//                   tuser: color_present
// m_axis       out  tdata: point_x, point_y, point_z, red, green, blue
// cfg          in   cfg_we_i, cfg_addr_i, cfg_wdata_i (write only)
// Takes one word per cycle unless back-pressure on m_axis has filled the pipeline,
// which has 37 register stages: 4 front, 32 radix-2 divider, 1 output.
// Dropped pixels turn into bubbles in the second front stage.
// Each stage holds only while full and blocked, so bubbles are squeezed out.
// Reset clears valid bits and loads config defaults; no clearing pass.
`include "depth_pixel_backprojection_core_macros.svh"
module depth_pixel_backprojection_core import dpb_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [63:0]            s_axis_tdata,  // col, row, depth, blue, green, red
  input  logic                   s_axis_tuser,  // color_present
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [119:0]           m_axis_tdata,  // x, y, z, red, green, blue
  input  logic                   cfg_we_i,
  input  logic [CfgAddrBits-1:0] cfg_addr_i,
  input  logic [31:0]            cfg_wdata_i
);
  cfg_t        cfg_q;
  logic        f_valid, f_ready, d_valid, d_ready, out_en, out_valid_q;
  side_t       f_side, d_side;
  logic [63:0] f_px, f_py;
  logic [31:0] qx, qy, x_d, y_d;
  logic [119:0] data_q;
  logic        pass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal_x       <= '0;
      cfg_q.focal_y       <= '0;
      cfg_q.center_x      <= '0;
      cfg_q.center_y      <= '0;
      cfg_q.depth_unit    <= DepthScaleReset;
      cfg_q.invalid_depth <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegFocalX:     cfg_q.focal_x       <= cfg_wdata_i;
        RegFocalY:     cfg_q.focal_y       <= cfg_wdata_i;
        RegCenterX:    cfg_q.center_x      <= cfg_wdata_i;
        RegCenterY:    cfg_q.center_y      <= cfg_wdata_i;
        RegDepthScale: cfg_q.depth_unit    <= cfg_wdata_i;
        RegInvalid:    cfg_q.invalid_depth <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dpb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni,
    .cfg_i    (cfg_q),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .col_i    (s_axis_tdata[11:0]),
    .row_i    (s_axis_tdata[23:12]),
    .depth_i  (s_axis_tdata[39:24]),
    .blue_i   (s_axis_tdata[47:40]),
    .green_i  (s_axis_tdata[55:48]),
    .red_i    (s_axis_tdata[63:56]),
    .color_i  (s_axis_tuser),
    .valid_o  (f_valid),
    .ready_i  (f_ready),
    .side_o   (f_side),
    .prod_x_o (f_px),
    .prod_y_o (f_py)
  );

  dpb_divider u_div (
    .clk_i, .rst_ni,
    .focal_x_i (cfg_q.focal_x),
    .focal_y_i (cfg_q.focal_y),
    .valid_i   (f_valid),
    .ready_o   (f_ready),
    .side_i    (f_side),
    .prod_x_i  (f_px),
    .prod_y_i  (f_py),
    .valid_o   (d_valid),
    .ready_i   (d_ready),
    .side_o    (d_side),
    .quot_x_o  (qx),
    .quot_y_o  (qy)
  );

  assign out_en  = !out_valid_q || m_axis_tready;
  assign d_ready = out_en;
  assign pass    = (cfg_q.focal_x == 32'd0) || (cfg_q.focal_y == 32'd0);

  // zero focal: pass coordinates through; else saturate the sign-magnitude quotient (overflow means at least 2^32)
  always_comb begin
    if (pass) begin
      x_d = {4'd0, d_side.col, 16'd0};
      y_d = {4'd0, d_side.row, 16'd0};
    end else begin
      if (d_side.neg_x) x_d = (d_side.ovf_x || qx[31]) ? 32'h8000_0000 : -qx;
      else              x_d = (d_side.ovf_x || qx[31]) ? 32'h7FFF_FFFF : qx;
      if (d_side.neg_y) y_d = (d_side.ovf_y || qy[31]) ? 32'h8000_0000 : -qy;
      else              y_d = (d_side.ovf_y || qy[31]) ? 32'h7FFF_FFFF : qy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && d_valid) begin
      data_q <= {d_side.blue, d_side.green, d_side.red, d_side.zs, y_d, x_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = data_q;

  `DPB_ASSERT_NEXT(a_out_hold, out_valid_q && !m_axis_tready, out_valid_q, "output word lost")
  `DPB_ASSERT_IMPL(a_z_floor, out_valid_q, data_q[95:64] > 32'd655, "depth at or below minimum")
  `DPB_ASSERT_IMPL(a_in_ready, !s_axis_tready, !m_axis_tready && out_valid_q, "input blocked")
endmodule

// ===== design/dpb_front.sv =====
`timescale 1ns / 1ps
module dpb_front import dpb_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [11:0] col_i,
  input  logic [11:0] row_i,
  input  logic [15:0] depth_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  red_i,
  input  logic        color_i,
  output logic        valid_o,
  input  logic        ready_i,
  output side_t       side_o,
  output logic [63:0] prod_x_o,
  output logic [63:0] prod_y_o
);
  localparam logic [11:0] CoordMask = 12'((32'd1 << COORD_BITS) - 32'd1);

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q, v2_d;
  logic [47:0] p1_q;
  logic [11:0] u1_q, r1_q, u2_q, r2_q, u3_q, r3_q;
  logic [7:0]  red1_q, grn1_q, blu1_q, red2_q, grn2_q, blu2_q, red3_q, grn3_q, blu3_q;
  logic [31:0] zs2_q, zs3_q, magx2_q, magy2_q;
  logic        negx2_q, negy2_q, negx3_q, negy3_q;
  logic [63:0] px3_q, py3_q, px4_q, py4_q;
  side_t       side4_q;

  logic [47:0] zsum;
  logic [39:0] z, diff;
  logic [31:0] zs;
  logic        drop;
  logic [33:0] dx, dy;

  assign en4 = !v4_q || ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;

  always_comb begin
    zsum = p1_q + DepthRound;
    z    = zsum[47:8];
    diff = (z >= {8'd0, cfg_i.invalid_depth}) ? z - {8'd0, cfg_i.invalid_depth}
                                              : {8'd0, cfg_i.invalid_depth} - z;
    drop = (diff <= InvalidTol) || (z <= MinDepth);
    zs   = (z[39:32] != 8'd0) ? 32'hFFFF_FFFF : z[31:0];
    dx   = {6'd0, u1_q, 16'd0} - {{2{cfg_i.center_x[31]}}, cfg_i.center_x};
    dy   = {6'd0, r1_q, 16'd0} - {{2{cfg_i.center_y[31]}}, cfg_i.center_y};
    v2_d = v1_q && !drop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v2_d;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p1_q   <= depth_i * cfg_i.depth_unit;
      u1_q   <= col_i & CoordMask;
      r1_q   <= row_i & CoordMask;
      red1_q <= color_i ? red_i : GrayLevel;
      grn1_q <= color_i ? green_i : GrayLevel;
      blu1_q <= color_i ? blue_i : GrayLevel;
    end
    if (en2) begin
      zs2_q   <= zs;
      negx2_q <= dx[33];
      negy2_q <= dy[33];
      magx2_q <= dx[33] ? 32'(-dx) : dx[31:0];
      magy2_q <= dy[33] ? 32'(-dy) : dy[31:0];
      u2_q    <= u1_q;
      r2_q    <= r1_q;
      red2_q  <= red1_q;
      grn2_q  <= grn1_q;
      blu2_q  <= blu1_q;
    end
    if (en3) begin
      px3_q   <= magx2_q * zs2_q;
      py3_q   <= magy2_q * zs2_q;
      zs3_q   <= zs2_q;
      negx3_q <= negx2_q;
      negy3_q <= negy2_q;
      u3_q    <= u2_q;
      r3_q    <= r2_q;
      red3_q  <= red2_q;
      grn3_q  <= grn2_q;
      blu3_q  <= blu2_q;
    end
    if (en4) begin
      px4_q         <= px3_q;
      py4_q         <= py3_q;
      side4_q.neg_x <= negx3_q;
      side4_q.neg_y <= negy3_q;
      side4_q.ovf_x <= px3_q[63:32] >= cfg_i.focal_x;
      side4_q.ovf_y <= py3_q[63:32] >= cfg_i.focal_y;
      side4_q.col   <= u3_q;
      side4_q.row   <= r3_q;
      side4_q.zs    <= zs3_q;
      side4_q.red   <= red3_q;
      side4_q.green <= grn3_q;
      side4_q.blue  <= blu3_q;
    end
  end

  assign valid_o  = v4_q;
  assign side_o   = side4_q;
  assign prod_x_o = px4_q;
  assign prod_y_o = py4_q;
endmodule

// ===== design/dpb_divider.sv =====
`timescale 1ns / 1ps
`include "depth_pixel_backprojection_core_macros.svh"
module dpb_divider import dpb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] focal_x_i,
  input  logic [31:0] focal_y_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  side_t       side_i,
  input  logic [63:0] prod_x_i,
  input  logic [63:0] prod_y_i,
  output logic        valid_o,
  input  logic        ready_i,
  output side_t       side_o,
  output logic [31:0] quot_x_o,
  output logic [31:0] quot_y_o
);
  logic              valid_q [QBITS];
  logic [31:0]       remx_q  [QBITS];
  logic [31:0]       remy_q  [QBITS];
  logic [31:0]       lowx_q  [QBITS];
  logic [31:0]       lowy_q  [QBITS];
  logic [31:0]       qx_q    [QBITS];
  logic [31:0]       qy_q    [QBITS];
  side_t             side_q  [QBITS];
  logic [QBITS:0]    en;

  always_comb begin
    en[QBITS] = ready_i;
    for (int k = QBITS - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end
  assign ready_o = en[0];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic        vin;
    logic [31:0] rx_in, ry_in, lx_in, ly_in, qx_in, qy_in;
    side_t       s_in;
    logic [32:0] tx, ty;
    logic        gex, gey;

    if (k == 0) begin : g_first
      assign vin   = valid_i;
      assign rx_in = prod_x_i[63:32];
      assign ry_in = prod_y_i[63:32];
      assign lx_in = prod_x_i[31:0];
      assign ly_in = prod_y_i[31:0];
      assign qx_in = '0;
      assign qy_in = '0;
      assign s_in  = side_i;
    end else begin : g_next
      assign vin   = valid_q[k-1];
      assign rx_in = remx_q[k-1];
      assign ry_in = remy_q[k-1];
      assign lx_in = lowx_q[k-1];
      assign ly_in = lowy_q[k-1];
      assign qx_in = qx_q[k-1];
      assign qy_in = qy_q[k-1];
      assign s_in  = side_q[k-1];
    end

    // shift in one dividend bit, subtract when it fits
    assign tx  = {rx_in, lx_in[31]};
    assign ty  = {ry_in, ly_in[31]};
    assign gex = tx >= {1'b0, focal_x_i};
    assign gey = ty >= {1'b0, focal_y_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en[k]) begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        remx_q[k] <= gex ? 32'(tx - {1'b0, focal_x_i}) : tx[31:0];
        remy_q[k] <= gey ? 32'(ty - {1'b0, focal_y_i}) : ty[31:0];
        lowx_q[k] <= {lx_in[30:0], 1'b0};
        lowy_q[k] <= {ly_in[30:0], 1'b0};
        qx_q[k]   <= {qx_in[30:0], gex};
        qy_q[k]   <= {qy_in[30:0], gey};
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o  = valid_q[QBITS-1];
  assign side_o   = side_q[QBITS-1];
  assign quot_x_o = qx_q[QBITS-1];
  assign quot_y_o = qy_q[QBITS-1];

  `DPB_ASSERT_IMPL(a_rem_x_below, valid_q[QBITS-1] && !side_q[QBITS-1].ovf_x, remx_q[QBITS-1] < focal_x_i, "x remainder not below focal")
  `DPB_ASSERT_IMPL(a_rem_y_below, valid_q[QBITS-1] && !side_q[QBITS-1].ovf_y, remy_q[QBITS-1] < focal_y_i, "y remainder not below focal")
  `DPB_ASSERT_IMPL(a_stall_full, !ready_o, valid_q[QBITS-1] && !ready_i, "divider stalled while not full at exit")
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import dpb_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 60;
  localparam logic [CfgAddrBits-1:0] RegUnused = 3'd7;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } point_t;

  class point_scoreboard;
    cfg_t   regs;
    point_t points_q[$];
    int     errors;

    function new();
      regs = '0;
      regs.depth_unit = DepthScaleReset;
      errors = 0;
    endfunction

    function logic [47:0] scaled_depth(logic [15:0] raw);
      logic [47:0] prod;
      prod = 48'(raw) * 48'(regs.depth_unit) + DepthRound;
      return prod >> 8;
    endfunction

    function logic [31:0] project(logic [11:0] coord, logic [31:0] ctr, logic [31:0] focal,
                                  logic [31:0] zs);
      logic signed [63:0] d;
      logic [63:0] mag;
      logic [127:0] q;
      logic neg;
      d = $signed({36'b0, coord, 16'b0}) - $signed({{32{ctr[31]}}, ctr});
      neg = d[63];
      mag = neg ? 64'(-d) : 64'(d);
      q = (128'(mag) * 128'(zs)) / 128'(focal);
      if (neg) return (q >= 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
      return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row, logic [15:0] raw,
                             logic [7:0] b, logic [7:0] g, logic [7:0] r, logic cp);
      logic [47:0] z;
      logic [47:0] diff;
      point_t p;
      z = scaled_depth(raw);
      diff = (z >= 48'(regs.invalid_depth)) ? z - 48'(regs.invalid_depth)
                                            : 48'(regs.invalid_depth) - z;
      // drop missing and too-near samples
      if (diff <= 48'(InvalidTol) || z <= 48'(MinDepth)) return;
      p.z = (z > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : z[31:0];
      if (regs.focal_x != 0 && regs.focal_y != 0) begin
        p.x = project(col, regs.center_x, regs.focal_x, p.z);
        p.y = project(row, regs.center_y, regs.focal_y, p.z);
      end else begin
        p.x = {4'b0, col, 16'b0};
        p.y = {4'b0, row, 16'b0};
      end
      p.red   = cp ? r : GrayLevel;
      p.green = cp ? g : GrayLevel;
      p.blue  = cp ? b : GrayLevel;
      points_q = {points_q, p};
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_point(logic [119:0] d);
      point_t p;
      if (points_q.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      p = points_q.pop_front();
      report("point_x", p.x, d[31:0]);
      report("point_y", p.y, d[63:32]);
      report("point_z", p.z, d[95:64]);
      report("red", 32'(p.red), 32'(d[103:96]));
      report("green", 32'(p.green), 32'(d[111:104]));
      report("blue", 32'(p.blue), 32'(d[119:112]));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;  // col, row, depth, blue, green, red
  logic s_axis_tuser;         // color_present
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [119:0] m_axis_tdata; // x, y, z, red, green, blue
  logic cfg_we_i;
  logic [CfgAddrBits-1:0] cfg_addr_i;
  logic [31:0] cfg_wdata_i;

  point_scoreboard sb;
  int unsigned cycles = 0;
  int unsigned points_seen = 0;
  bit steady;
  bit held_once = 1'b0;
  int hold_left = 0;
  logic [15:0] near_raw;

  depth_pixel_backprojection_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_point(m_axis_tdata);
      points_seen <= points_seen + 1;
    end
  end

  // receiver: random stalls, one long hold to back up the pipeline
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!held_once && points_seen >= 150) begin
      held_once <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 99) == 0) begin
      hold_left <= $urandom_range(10, 40);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 9) < 7);
    end
  end

  task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [15:0] raw,
                            logic [7:0] b, logic [7:0] g, logic [7:0] r, logic cp);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r, g, b, raw, row, col};
    s_axis_tuser <= cp;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(col, row, raw, b, g, r, cp);
    if (steady) return;
    case ($urandom_range(0, 19))
      0:       gap = $urandom_range(10, 40);
      1, 2, 3: gap = $urandom_range(1, 3);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_regs(cfg_t c);
    logic [31:0] vals[6];
    vals = '{c.focal_x, c.focal_y, c.center_x, c.center_y, c.depth_unit, c.invalid_depth};
    // an unmapped index must be ignored
    cfg_we_i <= 1'b1;
    cfg_addr_i <= RegUnused;
    cfg_wdata_i <= $urandom;
    @(posedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_addr_i <= i[CfgAddrBits-1:0];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sb.regs = c;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (sb.points_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_depth();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 20));
      1:       return 16'hFFFF;
      2, 3:    return near_raw + 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_pixels(int count);
    for (int i = 0; i < count; i++)
      send_pixel(12'($urandom), 12'($urandom), pick_depth(), 8'($urandom), 8'($urandom),
                 8'($urandom), $urandom_range(0, 3) != 0);
  endtask

  initial begin
    cfg_t c;
    sb = new();
    steady = 1'b0;
    near_raw = 16'd1000;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero focal lengths pass coordinates through
    send_pixel(12'd0, 12'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(12'hFFF, 12'd0, 16'd10, 8'h12, 8'h34, 8'h56, 1'b1);
    send_pixel(12'd0, 12'hFFF, 16'd11, 8'hAA, 8'h55, 8'hA5, 1'b0);
    send_pixel(12'd1, 12'd2, 16'd9, 8'h01, 8'h02, 8'h03, 1'b1);
    send_pixel(12'd640, 12'd480, 16'd1000, 8'hFF, 8'h00, 8'h80, 1'b0);
    send_pixel(12'hAAA, 12'h555, 16'hAAAA, 8'h55, 8'hAA, 8'h0F, 1'b1);
    send_pixel(12'h555, 12'hAAA, 16'h5555, 8'hAA, 8'h55, 8'hF0, 1'b1);
    drain();

    // typical camera, with huge depth and near-invalid pixels
    c.focal_x = 32'd525 << 16;
    c.focal_y = 32'd525 << 16;
    c.center_x = 32'h013F_8000;
    c.center_y = 32'h00EF_8000;
    c.depth_unit = DepthScaleReset;
    c.invalid_depth = 32'(sb.scaled_depth(16'd1000));
    near_raw = 16'd1000;
    write_regs(c);
    send_pixel(12'd0, 12'd0, 16'd1000, 8'h11, 8'h22, 8'h33, 1'b1);
    send_pixel(12'd0, 12'd0, 16'd1001, 8'h11, 8'h22, 8'h33, 1'b1);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'h11, 8'h22, 8'h33, 1'b0);
    send_pixel(12'd320, 12'd240, 16'd500, 8'h44, 8'h55, 8'h66, 1'b1);
    random_pixels(170);
    drain();

    // extremes: saturating projection and depth
    c.focal_x = 32'd1;
    c.focal_y = 32'hFFFF_FFFF;
    c.center_x = 32'h7FFF_FFFF;
    c.center_y = 32'h8000_0000;
    c.depth_unit = 32'hFFFF_FFFF;
    c.invalid_depth = 32'hFFFF_FFFF;
    near_raw = 16'd255;
    write_regs(c);
    send_pixel(12'd0, 12'hFFF, 16'hFFFF, 8'h01, 8'h02, 8'h03, 1'b1);
    send_pixel(12'hFFF, 12'd0, 16'd1, 8'h01, 8'h02, 8'h03, 1'b1);
    random_pixels(130);
    drain();

    // one focal length zero, no idling on either side
    c.focal_x = 32'h0001_0000;
    c.focal_y = 32'd0;
    c.center_x = 32'd0;
    c.center_y = 32'd0;
    c.depth_unit = 32'h0100_0000;
    c.invalid_depth = 32'd0;
    near_raw = 16'd5;
    write_regs(c);
    steady = 1'b1;
    random_pixels(120);
    steady = 1'b0;
    drain();

    // zero scale drops everything
    c.depth_unit = 32'd0;
    write_regs(c);
    random_pixels(30);
    drain();

    // random settings
    for (int k = 0; k < 3; k++) begin
      c.focal_x = $urandom;
      c.focal_y = $urandom_range(0, 3) == 0 ? $urandom_range(1, 65535) : $urandom;
      c.center_x = $urandom;
      c.center_y = $urandom;
      c.depth_unit = $urandom_range(0, 1) ? $urandom_range(1, 200000) : $urandom;
      near_raw = 16'($urandom);
      sb.regs.depth_unit = c.depth_unit;
      c.invalid_depth = 32'(sb.scaled_depth(near_raw));
      write_regs(c);
      random_pixels(120);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
